// ----- rtl/dqks_pkg.sv -----
// package for the deque with key search: field widths, codes, request and
// result structs, sequencer state type
// no dependencies
package dqks_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    match_position;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

endpackage

// ----- rtl/dqks_store.sv -----
// entry store: circular key memory, one write port and one registered read port
// depends on dqks_pkg
module dqks_store
    import dqks_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [KEY_W-1:0] wr_data,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [KEY_W-1:0] rd_data
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/dqks_ctrl.sv -----
// sequencer: head and count pointers, shared slot adder, search walk with one
// comparator, result hold
// depends on dqks_pkg
module dqks_ctrl
    import dqks_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  req_t                    req,
    output logic                    busy,
    input  logic                    out_room,
    output logic                    res_valid,
    output rsp_t                    res,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output logic signed [KEY_W-1:0] wr_data,
    output logic [IDX_W-1:0]        rd_addr,
    input  logic signed [KEY_W-1:0] rd_data
);

    localparam int SUM_W = CNT_W + 1;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        rd_off_reg, rd_off_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]        cmp_off_reg, cmp_off_next;
    rsp_t                    res_reg, res_next;

    rsp_t             res_comb;
    logic [CNT_W-1:0] slot_off;
    logic [SUM_W-1:0] slot_sum;
    logic [IDX_W-1:0] slot_addr;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;
    logic             full;
    logic             empty;
    logic             issue;
    logic             match;
    logic             done;

    // shared slot adder: head plus offset, wrapped once
    assign slot_off  = (state_reg == S_SEARCH) ? rd_off_reg : count_reg;
    assign slot_sum  = SUM_W'(head_reg) + SUM_W'(slot_off);
    assign slot_addr = (slot_sum >= SUM_W'(DEPTH)) ? IDX_W'(slot_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(slot_sum);

    // head moves with wrap
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // search walk: one read issued and one compare per cycle
    assign issue = (rd_off_reg != count_reg);
    assign match = cmp_valid_reg && (rd_data == key_reg);

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = slot_addr;
    assign wr_data = req.key_value;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        rd_off_reg  <= rd_off_next;
        cmp_off_reg <= cmp_off_next;
        res_reg     <= res_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        rd_off_next    = rd_off_reg;
        cmp_valid_next = 1'b0;
        cmp_off_next   = cmp_off_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_addr;
        res_valid      = 1'b0;
        done           = 1'b0;

        res_comb.status         = STATUS_DONE;
        res_comb.found          = 1'b0;
        res_comb.match_position = '0;
        res_comb.entry_count    = COUNT_W'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    done = 1'b1;
                    unique case (req.operation)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_comb.status = STATUS_FULL;
                            end
                            else
                            begin
                                head_next  = head_dec;
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_comb.status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_comb.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_comb.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH:
                        begin
                            done        = 1'b0;
                            key_next    = req.key_value;
                            rd_off_next = '0;
                            state_next  = S_SEARCH;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                    res_comb.entry_count = COUNT_W'(count_next);
                end
            end
            S_SEARCH:
            begin
                if (issue)
                begin
                    rd_off_next    = rd_off_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_off_next   = rd_off_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    res_comb.found          = 1'b1;
                    res_comb.match_position = POS_W'(cmp_off_reg);
                end
                done = match || !issue;
            end
            S_FINISH:
            begin
                res_valid = out_room;
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the result on, or hold it while the output is full
        if (done)
        begin
            if (out_room)
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                res_next   = res_comb;
                state_next = S_FINISH;
            end
        end

        res = (state_reg == S_FINISH) ? res_reg : res_comb;
    end

endmodule

// ----- rtl/deque_with_key_search.sv -----
// top level of the deque with key search: sequencer, entry store, output register
// depends on dqks_pkg, dqks_store, dqks_ctrl
//
// Usage:
//   Requests enter on req (operation, key_value) with req_valid; a request is
//   taken at a clock edge where req_valid is high and req_stall is low.
//   Every request gives one result on rsp (status, found, match_position,
//   entry_count) with rsp_valid, taken when rsp_stall is low.
//   Push and pop requests finish in the cycle they are taken; the result is
//   registered in the output register and, when that has room, req_stall stays low.
//   A search walks the stored entries front to back, one memory read and one
//   compare per cycle, and stops at the first match; the walk is paced by the
//   single read port of the entry memory and the one comparator. req_stall
//   is high while the walk runs.
//   When rsp_stall holds the output register, one more request is taken; its
//   result waits inside and req_stall stays high until it moves on.
//   Reset leaves the deque empty with the head at slot zero; the entry memory
//   is not cleared and only written slots are ever compared.
module deque_with_key_search
    import dqks_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                    busy;
    logic                    out_room;
    logic                    res_valid;
    rsp_t                    res;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [KEY_W-1:0] rd_data;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    assign req_stall = busy;

    // sequencer
    dqks_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .out_room  (out_room),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // entry memory
    dqks_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign out_room = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a result is only handed on when the output register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_room)
        else $error("result handed on while output register is held");

    // a dropped push reports a full deque
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == STATUS_FULL) |-> (res.entry_count == COUNT_W'(DEPTH)))
        else $error("push dropped while deque not full");

    // a match is only reported by a completed search
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (res.status == STATUS_DONE))
        else $error("match reported with a failure status");

    // a taken search request holds off the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.operation == OP_SEARCH) |=> req_stall)
        else $error("search request did not hold off the next request");

endmodule
